// ----- rtl/skf_pkg.sv -----
// Shared types, register indexes and constants of the scalar Kalman filter.
`default_nettype none

package skf_pkg;

  localparam int DATA_W            = 32;
  localparam int FRAC_BITS_DEFAULT = 16;
  localparam int CFG_IDX_W         = 3;

  localparam logic [CFG_IDX_W-1:0] REG_TRANS_GAIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROC_NOISE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_EST   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_COV   = 3'd4;

  localparam logic [DATA_W-1:0] RST_TRANS_GAIN = 32'd65536;
  localparam logic [DATA_W-1:0] RST_PROC_NOISE = 32'd655;
  localparam logic [DATA_W-1:0] RST_MEAS_NOISE = 32'd65536;
  localparam logic [DATA_W-1:0] RST_INIT_EST   = 32'd0;
  localparam logic [DATA_W-1:0] RST_INIT_COV   = 32'd65536;

  // Datapath operations, one per controller step
  typedef enum logic [3:0] {
    OP_NOP   = 4'd0,
    OP_LATCH = 4'd1,
    OP_MPRED = 4'd2,
    OP_MA2   = 4'd3,
    OP_RA2   = 4'd4,
    OP_MCOV  = 4'd5,
    OP_RCOV  = 4'd6,
    OP_ADDQ  = 4'd7,
    OP_DINIT = 4'd8,
    OP_DSTEP = 4'd9,
    OP_MEST  = 4'd10,
    OP_REST  = 4'd11,
    OP_RNCOV = 4'd12,
    OP_DONE  = 4'd13
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } status_t;

endpackage

`default_nettype wire

// ----- rtl/skf_if.sv -----
// Channel interfaces: measurement input, result output, configuration write.
`default_nettype none

interface skf_meas_if;
  logic                              valid;
  logic                              ready;
  logic signed [skf_pkg::DATA_W-1:0] measurement;

  modport source (output valid, output measurement, input ready);
  modport sink   (input valid, input measurement, output ready);
endinterface

interface skf_res_if;
  logic                              valid;
  logic                              ready;
  logic signed [skf_pkg::DATA_W-1:0] estimate;
  logic        [skf_pkg::DATA_W-1:0] covariance;

  modport source (output valid, output estimate, output covariance, input ready);
  modport sink   (input valid, input estimate, input covariance, output ready);
endinterface

interface skf_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [skf_pkg::CFG_IDX_W-1:0]  index;
  logic [skf_pkg::DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/skf_datapath.sv -----
// Kalman filter datapath: config/state registers, shared multiplier, gain divider.
`default_nettype none

module skf_datapath #(
  parameter int FRAC_BITS = skf_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  skf_pkg::cmd_t                        cmd,
  output skf_pkg::status_t                     status,
  input  logic                                 cfg_we,
  input  logic [skf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [skf_pkg::DATA_W-1:0]           cfg_data,
  input  logic signed [skf_pkg::DATA_W-1:0]    measurement,
  output logic signed [skf_pkg::DATA_W-1:0]    estimate,
  output logic        [skf_pkg::DATA_W-1:0]    covariance
);

  localparam int W  = skf_pkg::DATA_W;
  localparam int MW = W + 2;              // multiplier operand width
  localparam int PW = 2 * MW;             // product width
  localparam int GW = FRAC_BITS + 1;      // gain width, gain <= 1.0
  localparam int CW = $clog2(FRAC_BITS + 1);
  localparam int DW = W + 1;              // P + R
  localparam int RW = W + 2;              // divider partial remainder
  localparam int TW = W + 3;              // rounded correction and sum

  localparam logic signed [PW-1:0] HALF  = PW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [PW-1:0] S_MAX = PW'(64'sd2147483647);
  localparam logic signed [PW-1:0] S_MIN = -PW'(64'sd2147483648);
  localparam logic signed [PW-1:0] U_MAX = PW'(64'hFFFF_FFFF);
  localparam logic signed [TW-1:0] T_MAX = TW'(64'sd2147483647);
  localparam logic signed [TW-1:0] T_MIN = -TW'(64'sd2147483648);
  localparam logic [GW-1:0]        ONE_G = GW'(1) << FRAC_BITS;

  function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v);
    return (v + HALF) >>> FRAC_BITS;
  endfunction

  // config and filter state
  logic        [W-1:0] trans_gain;
  logic        [W-1:0] proc_noise;
  logic        [W-1:0] meas_noise;
  logic signed [W-1:0] est_reg;
  logic        [W-1:0] cov_reg;

  // working registers
  logic signed [W-1:0]  meas;
  logic signed [PW-1:0] prod;
  logic signed [W-1:0]  pred;
  logic signed [W:0]    diff;
  logic        [W-1:0]  a2;
  logic        [W-1:0]  pcov;
  logic        [DW-1:0] den;
  logic        [RW-1:0] rem;
  logic        [GW-1:0] quo;
  logic        [CW-1:0] cnt;
  logic signed [TW-1:0] corr;
  logic signed [W-1:0]  est_res;
  logic        [W-1:0]  cov_res;

  logic signed [MW-1:0] mul_a;
  logic signed [MW-1:0] mul_b;
  logic signed [MW-1:0] ga_ext;
  logic signed [MW-1:0] mag_a;
  logic signed [PW-1:0] prod_rnd;
  logic        [GW-1:0] gain_eff;
  logic        [GW-1:0] one_minus;
  logic        [RW-1:0] den_ext;
  logic                 ge;
  logic        [RW-1:0] rsub;
  logic        [W:0]    addq;
  logic signed [TW-1:0] est_sum;

  assign ga_ext    = {{(MW-W){trans_gain[W-1]}}, trans_gain};
  assign mag_a     = trans_gain[W-1] ? -ga_ext : ga_ext;
  assign prod_rnd  = rnd(prod);
  assign gain_eff  = (den == '0) ? '0 : quo;   // zero denominator gives zero gain
  assign one_minus = ONE_G - gain_eff;
  assign den_ext   = {1'b0, den};
  assign ge        = rem >= den_ext;
  assign rsub      = ge ? rem - den_ext : rem;
  assign addq      = {1'b0, pcov} + {1'b0, proc_noise};
  assign est_sum   = {{(TW-W){pred[W-1]}}, pred} + corr;

  assign status.div_last = (cnt == CW'(FRAC_BITS));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      skf_pkg::OP_MPRED: begin
        mul_a = {{(MW-W){est_reg[W-1]}}, est_reg};
        mul_b = ga_ext;
      end
      skf_pkg::OP_MA2: begin
        mul_a = mag_a;
        mul_b = mag_a;
      end
      skf_pkg::OP_MCOV: begin
        mul_a = {{(MW-W){1'b0}}, cov_reg};
        mul_b = {{(MW-W){1'b0}}, a2};
      end
      skf_pkg::OP_MEST: begin
        mul_a = {{(MW-GW){1'b0}}, gain_eff};
        mul_b = {{(MW-W-1){diff[W]}}, diff};
      end
      skf_pkg::OP_REST: begin
        mul_a = {{(MW-GW){1'b0}}, one_minus};
        mul_b = {{(MW-W){1'b0}}, pcov};
      end
      default: begin
      end
    endcase
  end

  // config port and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      trans_gain <= skf_pkg::RST_TRANS_GAIN;
      proc_noise <= skf_pkg::RST_PROC_NOISE;
      meas_noise <= skf_pkg::RST_MEAS_NOISE;
      est_reg    <= skf_pkg::RST_INIT_EST;
      cov_reg    <= skf_pkg::RST_INIT_COV;
      cnt        <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          skf_pkg::REG_TRANS_GAIN: trans_gain <= cfg_data;
          skf_pkg::REG_PROC_NOISE: proc_noise <= cfg_data;
          skf_pkg::REG_MEAS_NOISE: meas_noise <= cfg_data;
          skf_pkg::REG_INIT_EST:   est_reg    <= cfg_data;
          skf_pkg::REG_INIT_COV:   cov_reg    <= cfg_data;
          default: begin
          end
        endcase
      end
      if (cmd.op == skf_pkg::OP_DONE) begin
        est_reg <= est_res;
        cov_reg <= cov_res;
      end
      if (cmd.op == skf_pkg::OP_DINIT) begin
        cnt <= '0;
      end else if (cmd.op == skf_pkg::OP_DSTEP) begin
        cnt <= cnt + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    unique case (cmd.op)
      skf_pkg::OP_LATCH: meas <= measurement;
      skf_pkg::OP_MA2: begin
        if (prod_rnd > S_MAX) begin
          pred <= S_MAX[W-1:0];
        end else if (prod_rnd < S_MIN) begin
          pred <= S_MIN[W-1:0];
        end else begin
          pred <= prod_rnd[W-1:0];
        end
      end
      skf_pkg::OP_RA2: begin
        a2   <= (prod_rnd > U_MAX) ? '1 : prod_rnd[W-1:0];
        diff <= {meas[W-1], meas} - {pred[W-1], pred};
      end
      skf_pkg::OP_RCOV: pcov <= (prod_rnd > U_MAX) ? '1 : prod_rnd[W-1:0];
      skf_pkg::OP_ADDQ: pcov <= addq[W] ? '1 : addq[W-1:0];
      skf_pkg::OP_DINIT: begin
        rem <= {{(RW-W){1'b0}}, pcov};
        den <= {1'b0, pcov} + {1'b0, meas_noise};
        quo <= '0;
      end
      skf_pkg::OP_DSTEP: begin
        // restoring division, one quotient bit per cycle
        rem <= {rsub[RW-2:0], 1'b0};
        quo <= {quo[GW-2:0], ge};
      end
      skf_pkg::OP_REST: corr <= prod_rnd[TW-1:0];
      skf_pkg::OP_RNCOV: begin
        cov_res <= prod_rnd[W-1:0];   // (1 - K) * P never exceeds P
        if (est_sum > T_MAX) begin
          est_res <= T_MAX[W-1:0];
        end else if (est_sum < T_MIN) begin
          est_res <= T_MIN[W-1:0];
        end else begin
          est_res <= est_sum[W-1:0];
        end
      end
      skf_pkg::OP_DONE: begin
        estimate   <= est_res;
        covariance <= cov_res;
      end
      default: begin
      end
    endcase
  end

  a_gain_le_one: assert property (@(posedge clk) disable iff (rst)
    cmd.op == skf_pkg::OP_MEST |-> gain_eff <= ONE_G)
    else $error("gain above one");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.op == skf_pkg::OP_DSTEP && den != '0 |=> rem < {den, 1'b0})
    else $error("divider remainder out of range");

  a_cov_shrinks: assert property (@(posedge clk) disable iff (rst)
    cmd.op == skf_pkg::OP_RNCOV |=> cov_res <= pcov)
    else $error("updated covariance exceeds prediction");

endmodule

`default_nettype wire

// ----- rtl/skf_ctrl.sv -----
// Kalman filter controller: sequences the datapath and owns the handshakes.
`default_nettype none

module skf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output skf_pkg::cmd_t    cmd,
  input  skf_pkg::status_t status
);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_MPRED = 13'b0000000000010,
    S_MA2   = 13'b0000000000100,
    S_RA2   = 13'b0000000001000,
    S_MCOV  = 13'b0000000010000,
    S_RCOV  = 13'b0000000100000,
    S_ADDQ  = 13'b0000001000000,
    S_DINIT = 13'b0000010000000,
    S_DSTEP = 13'b0000100000000,
    S_MEST  = 13'b0001000000000,
    S_REST  = 13'b0010000000000,
    S_RNCOV = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = skf_pkg::OP_NOP;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = skf_pkg::OP_LATCH;
          state_next = S_MPRED;
        end
      end
      S_MPRED: begin
        cmd.op     = skf_pkg::OP_MPRED;
        state_next = S_MA2;
      end
      S_MA2: begin
        cmd.op     = skf_pkg::OP_MA2;
        state_next = S_RA2;
      end
      S_RA2: begin
        cmd.op     = skf_pkg::OP_RA2;
        state_next = S_MCOV;
      end
      S_MCOV: begin
        cmd.op     = skf_pkg::OP_MCOV;
        state_next = S_RCOV;
      end
      S_RCOV: begin
        cmd.op     = skf_pkg::OP_RCOV;
        state_next = S_ADDQ;
      end
      S_ADDQ: begin
        cmd.op     = skf_pkg::OP_ADDQ;
        state_next = S_DINIT;
      end
      S_DINIT: begin
        cmd.op     = skf_pkg::OP_DINIT;
        state_next = S_DSTEP;
      end
      S_DSTEP: begin
        cmd.op = skf_pkg::OP_DSTEP;
        if (status.div_last) begin
          state_next = S_MEST;
        end
      end
      S_MEST: begin
        cmd.op     = skf_pkg::OP_MEST;
        state_next = S_REST;
      end
      S_REST: begin
        cmd.op     = skf_pkg::OP_REST;
        state_next = S_RNCOV;
      end
      S_RNCOV: begin
        cmd.op     = skf_pkg::OP_RNCOV;
        state_next = S_DONE;
      end
      S_DONE: begin
        // hold the result until the output register is free
        if (!out_valid || out_ready) begin
          cmd.op     = skf_pkg::OP_DONE;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.op == skf_pkg::OP_DONE) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction accepted while busy");

  a_done_waits: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && out_valid && !out_ready |=> state == S_DONE && out_valid)
    else $error("result dropped under stall");

  a_done_publishes: assert property (@(posedge clk) disable iff (rst)
    cmd.op == skf_pkg::OP_DONE |=> out_valid && state == S_IDLE)
    else $error("result not presented after update");

endmodule

`default_nettype wire

// ----- rtl/scalar_kalman_filter.sv -----
// Scalar Kalman filter top level: Q16.16 one-dimensional predict/update per measurement.
//
// Channels: meas carries one signed measurement per transaction; result carries the
// updated estimate and covariance; cfg writes the registers by index (0 transition
// gain, 1 process noise, 2 measurement noise, 3 initial estimate, 4 initial
// covariance). Writing index 3 or 4 also loads the filter state; other indexes are
// dropped. cfg is always ready and must be written only while the filter is idle; the
// block itself does not enforce this. One item is in flight at a time, as a new
// measurement is taken only once the last one has finished. The gain divider resolves
// one quotient bit per cycle; the other steps are the latch, the single shared
// multiplier and its rounding/saturation stage, the process noise add, the divider
// setup and the final publish.
// Reset (synchronous, rst high) restores the register defaults and the state
// estimate 0, covariance 1.0, and empties the output register.
// The output register holds a finished result while the receiver stalls; a new
// measurement is still taken and processed, and its result waits in the last step
// until the output register drains.
`default_nettype none

module scalar_kalman_filter #(
  parameter int FRAC_BITS = skf_pkg::FRAC_BITS_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  skf_meas_if.sink  meas,
  skf_res_if.source result,
  skf_cfg_if.sink   cfg
);

  skf_pkg::cmd_t    cmd;
  skf_pkg::status_t status;

  assign cfg.ready = 1'b1;

  skf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (meas.valid),
    .in_ready  (meas.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd),
    .status    (status)
  );

  skf_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg.valid),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .measurement (meas.measurement),
    .estimate    (result.estimate),
    .covariance  (result.covariance)
  );

endmodule

`default_nettype wire
